### design/lkot_pkg.sv
// Shared constants and the cell control struct for the LRU key order tracker.
package lkot_pkg;

  localparam int KEY_W         = 32;
  localparam int CAP_W         = 4;
  localparam int OCC_W         = 4;
  localparam int DEFAULT_DEPTH = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic cmp_en;       // register the per-cell match against the access key
    logic upd_en;       // apply the shift and load of this cycle
    logic shift_all;    // every cell takes its right neighbor (head removal)
    logic load_en;      // write the access key at the tail position
    logic load_tail_m1; // tail position is count - 1 instead of count
  } cell_ctrl_t;

endpackage

### design/lkot_cell.sv
// One key slot of the tracker chain with its match flag and shift logic.
module lkot_cell
  import lkot_pkg::*;
#(
  parameter int CntW = 4,
  parameter int Idx  = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CntW-1:0]  count_i,
  input  logic [KEY_W-1:0] access_key_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic             seen_i,
  output logic             seen_o,
  output logic [KEY_W-1:0] key_o,
  output logic [KEY_W-1:0] next_key_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             match_q, match_d;
  logic             occupied;
  logic [CntW-1:0]  tail;
  logic             load;
  logic             shift;

  assign occupied = CntW'(Idx) < count_i;
  assign tail     = ctrl_i.load_tail_m1 ? count_i - CntW'(1) : count_i;
  assign seen_o   = seen_i | match_q;
  assign load     = ctrl_i.upd_en & ctrl_i.load_en & (CntW'(Idx) == tail);
  assign shift    = ctrl_i.upd_en & (ctrl_i.shift_all | seen_o);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = occupied & (key_q == access_key_i);
    end
  end

  always_comb begin
    key_d = key_q;
    if (load) begin
      key_d = access_key_i;
    end else if (shift) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o      = key_q;
  assign next_key_o = key_d;

endmodule

### design/lru_key_order_tracker.sv
// Top level of the LRU key order tracker: sequencer, cell chain and result register.
//
// The tracker keeps up to the configured capacity of distinct 32-bit keys in a
// chain of cells, oldest in cell 0. Each accepted key passes a compare state,
// in which every cell compares its slot with the key, and an update state, in
// which the chain shifts left by one from the matching cell (a hit) or from the
// head (an eviction) and the key is written at the tail. When the capacity has
// been lowered below the current occupancy, a miss stays in the update state to
// drop each additional head key in turn. A new key is taken only while the
// sequencer is idle, so the next key is accepted only after the previous one
// has left the update state. The result register lets a finished result wait
// for the consumer while the next key is accepted, and the update cycle holds
// while a previous result has not been taken. The capacity register can be
// written in any cycle (its ready is always high) but should only change while
// idle; a value of zero acts as one and values above the depth act as the depth.
module lru_key_order_tracker
  import lkot_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [KEY_W-1:0] access_key_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic        [CAP_W-1:0] capacity_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic signed [KEY_W-1:0] evicted_key_o,
  output logic        [OCC_W-1:0] occupancy_o,
  output logic signed [KEY_W-1:0] oldest_key_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [KEY_W-1:0] key_q, key_d;

  // Eviction memory for misses that have to drop more than one head key.
  logic             evflag_q, evflag_d;
  logic [KEY_W-1:0] evkey_q, evkey_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic             hit_q, hit_d;
  logic             evicted_q, evicted_d;
  logic [KEY_W-1:0] evicted_key_q, evicted_key_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [KEY_W-1:0] oldest_q, oldest_d;

  cell_ctrl_t       ctrl;
  logic [CntW-1:0]  eff_cap;
  logic             out_free;
  logic             hit;

  logic             seen     [DEPTH+1];
  logic [KEY_W-1:0] slot     [DEPTH];
  logic [KEY_W-1:0] slot_nxt [DEPTH];

  // The capacity is clamped into the range one to the chain depth.
  always_comb begin
    if (32'(cap_q) > DEPTH) begin
      eff_cap = CntW'(DEPTH);
    end else if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // The match chain runs from the head; its far end tells whether any held key matched.
  assign seen[0] = 1'b0;
  assign hit     = seen[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] right_key;
    if (i == DEPTH - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_mid
      assign right_key = slot[i+1];
    end

    lkot_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .access_key_i (key_q),
      .right_key_i  (right_key),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .key_o        (slot[i]),
      .next_key_o   (slot_nxt[i])
    );
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cap_d         = cap_q;
    key_d         = key_q;
    evflag_d      = evflag_q;
    evkey_d       = evkey_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    hit_d         = hit_q;
    evicted_d     = evicted_q;
    evicted_key_d = evicted_key_q;
    occ_d         = occ_q;
    oldest_d      = oldest_q;
    ctrl          = '0;

    if (cfg_valid_i) begin
      cap_d = capacity_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d    = access_key_i;
          evflag_d = 1'b0;
          state_d  = ST_CMP;
        end
      end

      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_UPD;
      end

      ST_UPD: begin
        if (out_free) begin
          ctrl.upd_en = 1'b1;
          if (hit) begin
            // The matching cell closes its gap and the key goes to the tail.
            ctrl.load_en      = 1'b1;
            ctrl.load_tail_m1 = 1'b1;
          end else if (count_q < eff_cap) begin
            ctrl.load_en = 1'b1;
            count_d      = count_q + CntW'(1);
          end else if (count_q == eff_cap) begin
            ctrl.shift_all    = 1'b1;
            ctrl.load_en      = 1'b1;
            ctrl.load_tail_m1 = 1'b1;
          end else begin
            // Over capacity after a lowered setting: drop one head key and retry.
            ctrl.shift_all = 1'b1;
            count_d        = count_q - CntW'(1);
            if (!evflag_q) begin
              evflag_d = 1'b1;
              evkey_d  = slot[0];
            end
          end

          if (hit || count_q <= eff_cap) begin
            out_valid_d = 1'b1;
            hit_d       = hit;
            evicted_d   = evflag_q || (!hit && count_q == eff_cap);
            if (evflag_q) begin
              evicted_key_d = evkey_q;
            end else if (!hit && count_q == eff_cap) begin
              evicted_key_d = slot[0];
            end else begin
              evicted_key_d = '0;
            end
            occ_d    = OCC_W'(count_d);
            oldest_d = slot_nxt[0];
            state_d  = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      evflag_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      evflag_q    <= evflag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    evkey_q       <= evkey_d;
    hit_q         <= hit_d;
    evicted_q     <= evicted_d;
    evicted_key_q <= evicted_key_d;
    occ_q         <= occ_d;
    oldest_q      <= oldest_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;
  assign occupancy_o   = occ_q;
  assign oldest_key_o  = oldest_q;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the LRU key order tracker with a built-in order predictor.
`timescale 1ns / 100ps

module tb_top;
  import lkot_pkg::*;

  localparam int TRACK_DEPTH = DEFAULT_DEPTH;
  // Generous bound on the whole run, far above the slowest legal schedule.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to let pass after the last result before touching the capacity.
  localparam int unsigned SETTLE_CYCLES = TRACK_DEPTH + 4;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
    logic [KEY_W-1:0] oldest_key;
  } lru_result_t;

  // The scoreboard keeps its own copy of the key chain and the capacity, works
  // out the result of every accepted key and checks results in order.
  class lru_order_scoreboard;
    logic [KEY_W-1:0] key_chain[TRACK_DEPTH];
    int unsigned      held;
    logic [CAP_W-1:0] capacity_reg;
    lru_result_t      pending[$];
    int unsigned      errors;

    function new();
      held         = 0;
      capacity_reg = CAP_RESET;
      errors       = 0;
      foreach (key_chain[i]) key_chain[i] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity_reg = value;
    endfunction

    // Removes n keys starting at position pos and closes the gap.
    function void drop_span(int unsigned pos, int unsigned n);
      int unsigned i;
      if (pos >= held || n == 0) return;
      if (n > held - pos) n = held - pos;
      for (i = pos; i + n < held; i++) key_chain[i] = key_chain[i + n];
      held -= n;
    endfunction

    function void note_access(logic [KEY_W-1:0] key);
      int unsigned limit;
      int unsigned pos;
      int unsigned i;
      lru_result_t r;
      limit = capacity_reg;
      if (limit < 1) limit = 1;
      if (limit > TRACK_DEPTH) limit = TRACK_DEPTH;
      r   = '0;
      pos = held;
      for (i = 0; i < held; i++) begin
        if (pos == held && key_chain[i] == key) pos = i;
      end
      if (pos < held) begin
        r.hit = 1'b1;
        drop_span(pos, 1);
      end else if (held >= limit) begin
        r.evicted     = 1'b1;
        r.evicted_key = key_chain[0];
        drop_span(0, held - limit + 1);
      end
      if (held < TRACK_DEPTH) begin
        key_chain[held] = key;
        held++;
      end
      r.occupancy  = held[OCC_W-1:0];
      r.oldest_key = key_chain[0];
      pending.push_back(r);
    endfunction

    function void check_result(lru_result_t got);
      lru_result_t want;
      if (pending.size() == 0) begin
        $error("result with no access waiting: oldest_key %h", got.oldest_key);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %b, actual %b", want.hit, got.hit);
        errors++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %b, actual %b", want.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %h, actual %h", want.evicted_key, got.evicted_key);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        errors++;
      end
      if (got.oldest_key !== want.oldest_key) begin
        $error("oldest_key: expected %h, actual %h", want.oldest_key, got.oldest_key);
        errors++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic signed [KEY_W-1:0] access_key_i = '0;
  logic                    cfg_valid_i  = 1'b0;
  logic                    cfg_ready_o;
  logic        [CAP_W-1:0] capacity_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic                    hit_o;
  logic                    evicted_o;
  logic signed [KEY_W-1:0] evicted_key_o;
  logic        [OCC_W-1:0] occupancy_o;
  logic signed [KEY_W-1:0] oldest_key_o;

  // Idle and stall rates in percent of cycles. They change only through
  // nonblocking assignments so the receiver never races the main sequence.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  lru_order_scoreboard sb = new();

  lru_key_order_tracker #(
    .DEPTH(TRACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .access_key_i  (access_key_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .capacity_i    (capacity_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .occupancy_o   (occupancy_o),
    .oldest_key_o  (oldest_key_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side. Signals read here at the rising edge still hold their values
  // from before the edge, so a transaction is seen exactly when valid and
  // ready were both high. The ready for the next cycle is drawn afterwards.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{hit_o, evicted_o, evicted_key_o, occupancy_o, oldest_key_o});
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Presents one key and waits for its transaction. Valid is lowered only
  // when an idle gap is drawn, so back-to-back keys keep valid high.
  task automatic send_key(input logic [KEY_W-1:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    access_key_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(key);
  endtask

  // The capacity changes only while the tracker is idle: input withdrawn,
  // every expected result taken, and a further wait for the chain to settle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    capacity_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capacity(value);
    cfg_valid_i <= 1'b0;
  endtask

  // Hand-picked sequence: extreme keys, hits at the head, tail and middle, an
  // eviction, a capacity dropped below the occupancy (a hit that only
  // reorders, then a miss that drops several keys), a zero capacity acting as
  // one, and a capacity above the depth that saturates.
  task automatic run_directed();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h7FFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'd1);
    send_key(32'd2);
    send_key(32'd3);
    send_key(32'd4);
    send_key(32'h0000_0000);
    send_key(32'd4);
    send_key(32'd2);
    send_key(32'd5);
    write_capacity(4'd3);
    send_key(32'd3);
    send_key(32'd9);
    send_key(32'd9);
    write_capacity(4'd0);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
    send_key(32'hAAAA_AAAA);
    write_capacity(4'd15);
    for (int k = 10; k < 19; k++) send_key(k);
  endtask

  // Random keys, mostly drawn from a small pool sized just above the capacity
  // so that hits, fills and evictions all happen often; the rest are full
  // 32-bit values that exercise every key bit.
  task automatic run_random_segment(input logic [CAP_W-1:0] cap, input int unsigned items);
    logic [KEY_W-1:0] key_pool[16];
    int unsigned      limit;
    int unsigned      pool_top;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    limit = cap;
    if (limit < 1) limit = 1;
    if (limit > TRACK_DEPTH) limit = TRACK_DEPTH;
    pool_top = (limit + 2 > 15) ? 15 : limit + 2;
    for (int unsigned n = 0; n < items; n++) begin
      if ($urandom_range(99) < 75) send_key(key_pool[$urandom_range(pool_top)]);
      else send_key($urandom);
    end
  endtask

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    logic [CAP_W-1:0] cap_plan[16];

    // Phases: no idling, sender mostly idle, receiver mostly stalling, both.
    idle_by_phase  = '{0, 88, 0, 33};
    stall_by_phase = '{0, 0, 88, 33};
    // Capacity settings cover both extremes, zero, values above the depth and
    // drops below the occupancy left by the previous segment.
    cap_plan = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd5, 4'd3, 4'd9,
                 4'd4, 4'd7, 4'd6, 4'd12, 4'd1, 4'd8, 4'd3, 4'd15};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 4; s++) begin
        write_capacity(cap_plan[p * 4 + s]);
        send_idle_pct  <= idle_by_phase[p];
        recv_stall_pct <= stall_by_phase[p];
        run_random_segment(cap_plan[p * 4 + s], 38);
      end
    end

    // Drain: withdraw the input, wait for every result, then let the tail
    // of the last transaction settle before judging.
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### lru_key_order_tracker.f
design/lkot_pkg.sv
design/lkot_cell.sv
design/lru_key_order_tracker.sv
tb/sv/tb_top.sv
